// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising edge outside reset.
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mhpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpmc_pkg
// Types and constants shared by the sketch match counter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpmc_pkg;

  // Store geometry.
  localparam int MAX_SKETCHES = 64;
  localparam int SKETCH_LEN   = 128;
  localparam int STORE_DEPTH  = MAX_SKETCHES * SKETCH_LEN;
  localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int POS_CW       = (SKETCH_LEN > 1) ? $clog2(SKETCH_LEN) : 1;

  // Field widths.
  localparam int IDX_W   = 6;
  localparam int POS_W   = 7;
  localparam int HASH_W  = 64;
  localparam int CNT_W   = 8;
  localparam int CNT_MAX = 255;
  localparam int CFG_W   = 7;

  // Sketches in use never exceed the store or the index range.
  localparam int INDEX_LIMIT = 64;
  localparam int LIMIT_CAP   = (MAX_SKETCHES < INDEX_LIMIT) ? MAX_SKETCHES : INDEX_LIMIT;

  // Commands.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPARE = 1'b1;

  // Register indexes.
  localparam logic REG_SKETCH_COUNT = 1'b0;
  localparam logic REG_OUTPUT_ORDER = 1'b1;

  // Output orders.
  localparam logic ORDER_ASCENDING  = 1'b0;

  typedef struct packed {
    logic              command;
    logic [IDX_W-1:0]  sketch_index;
    logic [POS_W-1:0]  position;
    logic [HASH_W-1:0] hash_value;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_sketch;
    logic [IDX_W-1:0] partner_sketch;
    logic [CNT_W-1:0] match_count;
    logic             last_of_row;
  } result_t;

  // One row request as the back end works it off.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] first_partner;
    logic [IDX_W-1:0] total;
    logic             descending;
  } job_t;

  // Store write request from the front end.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [HASH_W-1:0] data;
  } wr_req_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/minhash_pairwise_match_count.sv -----
// ----------------------------------------------------------------------------
// minhash_pairwise_match_count
// MinHash sketch store with an all-pairs equal-word counter per row.
// ----------------------------------------------------------------------------
// Usage:
// A command beat is taken on a rising edge with start high and busy low.
// A load command writes one 64-bit word of one sketch; it gives no result.
// A compare command for row sketch i emits one result for every partner j
// with i < j < min(sketch_count, 64), ascending in j, or descending when
// output_order is 1. Each result beat is on out_result for one cycle with
// out_valid high; the receiver cannot stall and always takes it.
// A compare occupies the comparison unit while it reads all SKETCH_LEN
// word pairs of each partner, up to 63 partners, one word pair per cycle
// from the two read ports of the store. Up to two further compares queue
// while one runs. A load is taken every cycle when no compare is pending;
// behind compares it waits until they have finished reading the store.
// Configuration writes take effect at once and belong to idle periods.
// Reset clears the control state and the registers (sketch_count 2,
// ascending order); the store contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module minhash_pairwise_match_count
  import mhpmc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire item_t            in_item,
  output logic                  out_valid,
  output result_t               out_result,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  q_stat_t           q_stat;
  logic              push;
  job_t              push_job;
  logic              pop;
  job_t              head_job;
  logic              back_busy;
  wr_req_t           wr_req;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [HASH_W-1:0] rdata_a;
  logic [HASH_W-1:0] rdata_b;

  // Command intake and classification.
  mhpmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .back_busy (back_busy),
    .push      (push),
    .push_job  (push_job),
    .wr_req    (wr_req)
  );

  // Row request queue.
  mhpmc_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // Sketch store.
  mhpmc_ram #(
    .WIDTH (HASH_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (wr_req.en),
    .waddr   (wr_req.addr),
    .wdata   (wr_req.data),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Comparison unit.
  mhpmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .q_stat     (q_stat),
    .pop        (pop),
    .back_busy  (back_busy),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

// ----- rtl/mhpmc_ram.sv -----
// ----------------------------------------------------------------------------
// mhpmc_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpmc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic      [WIDTH-1:0]                       rdata_a,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                       rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/mhpmc_job_fifo.sv -----
// ----------------------------------------------------------------------------
// mhpmc_job_fifo
// Two-entry queue of row requests between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mhpmc_job_fifo
  import mhpmc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output q_stat_t   stat
);

  job_t       mem_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] count_r;

  // Status and head entry.
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign head_job   = mem_r[rptr_r];

  // Storage; entries carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  `CHK_SAME(a_no_push_full, push, !stat.full, "job pushed into a full queue")
  `CHK_SAME(a_no_pop_empty, pop, !stat.empty, "job popped from an empty queue")
  `CHK_ALWAYS(a_count_range, count_r != 2'd3, "queue fill level out of range")

endmodule

`default_nettype wire

// ----- rtl/mhpmc_front.sv -----
// ----------------------------------------------------------------------------
// mhpmc_front
// Accepts commands, holds the configuration and classifies each item:
// loads go to the store, compares with partners go to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mhpmc_front
  import mhpmc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire item_t            in_item,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire q_stat_t          q_stat,
  input  wire logic             back_busy,
  output logic                  push,
  output job_t                  push_job,
  output wr_req_t               wr_req
);

  logic             hold_valid_r;
  item_t            hold_item_r;
  logic [CFG_W-1:0] sketch_count_r;
  logic             output_order_r;

  logic             is_compare;
  logic [CFG_W-1:0] limit;
  logic [CFG_W-1:0] row_ext;
  logic             drop;
  logic             load_ok;
  logic             drain;
  logic             accept;

  // Sketches in use: the configured count capped by the store size.
  always_comb begin
    limit = sketch_count_r;
    if (limit > CFG_W'(LIMIT_CAP)) begin
      limit = CFG_W'(LIMIT_CAP);
    end
  end

  // Classification of the held item.
  assign is_compare = (hold_item_r.command == CMD_COMPARE);
  assign row_ext    = CFG_W'(hold_item_r.sketch_index);
  assign drop       = (limit < CFG_W'(2)) || (row_ext + CFG_W'(1) >= limit);
  assign load_ok    = (CFG_W'(hold_item_r.sketch_index) < CFG_W'(MAX_SKETCHES)) &&
                      (32'(hold_item_r.position) < 32'(SKETCH_LEN));

  // A load waits until all earlier compares have read the store.
  always_comb begin
    if (is_compare) begin
      drain = hold_valid_r && (drop || !q_stat.full);
    end else begin
      drain = hold_valid_r && !back_busy && q_stat.empty;
    end
  end

  assign busy   = hold_valid_r && !drain;
  assign accept = start && !busy;

  // Job for a compare that has partners.
  assign push                   = drain && is_compare && !drop;
  assign push_job.row           = hold_item_r.sketch_index;
  assign push_job.descending    = (output_order_r != ORDER_ASCENDING);
  assign push_job.total         = IDX_W'(limit - row_ext - CFG_W'(1));
  assign push_job.first_partner = push_job.descending ? IDX_W'(limit - CFG_W'(1))
                                                      : IDX_W'(row_ext + CFG_W'(1));

  // Store write for an in-range load.
  assign wr_req.en   = drain && !is_compare && load_ok;
  assign wr_req.addr = ADDR_W'(hold_item_r.sketch_index) * ADDR_W'(SKETCH_LEN) +
                       ADDR_W'(hold_item_r.position);
  assign wr_req.data = hold_item_r.hash_value;

  // Holding register for one beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (drain) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item_r <= in_item;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sketch_count_r <= CFG_W'(2);
      output_order_r <= ORDER_ASCENDING;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKETCH_COUNT: sketch_count_r <= cfg_wdata;
        REG_OUTPUT_ORDER: output_order_r <= cfg_wdata[0];
        default:          sketch_count_r <= sketch_count_r;
      endcase
    end
  end

  `CHK_SAME(a_write_when_quiet, wr_req.en, !back_busy && q_stat.empty,
            "store written while a compare may still read it")
  `CHK_SAME(a_job_has_partners, push, push_job.total != '0,
            "job queued with no partners")
  `CHK_NEXT(a_hold_after_accept, accept, hold_valid_r,
            "accepted beat not held")

endmodule

`default_nettype wire

// ----- rtl/mhpmc_back.sv -----
// ----------------------------------------------------------------------------
// mhpmc_back
// Works off row requests: reads one word pair per cycle, counts equal
// words per partner and emits one result per partner.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mhpmc_back
  import mhpmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire job_t              head_job,
  input  wire q_stat_t           q_stat,
  output logic                   pop,
  output logic                   back_busy,
  output logic      [ADDR_W-1:0] raddr_a,
  output logic      [ADDR_W-1:0] raddr_b,
  input  wire logic [HASH_W-1:0] rdata_a,
  input  wire logic [HASH_W-1:0] rdata_b,
  output logic                   out_valid,
  output result_t                out_result
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_r;
  logic [IDX_W-1:0]  row_r;
  logic [IDX_W-1:0]  part_r;
  logic [IDX_W-1:0]  rem_r;
  logic              desc_r;
  logic [POS_CW-1:0] pos_r;
  logic              last_pos;
  logic              last_part;

  // Compare stage registers.
  logic              s1_valid_r;
  logic              s1_first_r;
  logic              s1_last_pos_r;
  logic              s1_last_row_r;
  logic [IDX_W-1:0]  s1_row_r;
  logic [IDX_W-1:0]  s1_part_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W:0]    cnt_sum;
  logic [CNT_W-1:0]  cnt_nxt;

  logic              out_valid_r;
  result_t           out_result_r;

  assign back_busy = (state_r == ST_RUN);
  assign pop       = (state_r == ST_IDLE) && !q_stat.empty;
  assign last_pos  = (32'(pos_r) == SKETCH_LEN - 1);
  assign last_part = (rem_r == IDX_W'(1));

  // Word pair addresses for the current position.
  assign raddr_a = ADDR_W'(row_r) * ADDR_W'(SKETCH_LEN) + ADDR_W'(pos_r);
  assign raddr_b = ADDR_W'(part_r) * ADDR_W'(SKETCH_LEN) + ADDR_W'(pos_r);

  // Sequencer over partners and positions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_pos && last_part) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_r  <= head_job.row;
      part_r <= head_job.first_partner;
      rem_r  <= head_job.total;
      desc_r <= head_job.descending;
      pos_r  <= '0;
    end else if (state_r == ST_RUN) begin
      if (last_pos) begin
        pos_r  <= '0;
        rem_r  <= rem_r - IDX_W'(1);
        part_r <= desc_r ? part_r - IDX_W'(1) : part_r + IDX_W'(1);
      end else begin
        pos_r <= pos_r + POS_CW'(1);
      end
    end
  end

  // Tags that travel with the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= (state_r == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r    <= (pos_r == '0);
    s1_last_pos_r <= last_pos;
    s1_last_row_r <= last_part;
    s1_row_r      <= row_r;
    s1_part_r     <= part_r;
  end

  // Saturating match counter.
  always_comb begin
    cnt_sum = (s1_first_r ? '0 : {1'b0, cnt_r}) + (CNT_W + 1)'(rdata_a == rdata_b);
    cnt_nxt = (cnt_sum > (CNT_W + 1)'(CNT_MAX)) ? CNT_W'(CNT_MAX) : cnt_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result register: one beat per partner.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r && s1_last_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_last_pos_r) begin
      out_result_r.row_sketch     <= s1_row_r;
      out_result_r.partner_sketch <= s1_part_r;
      out_result_r.match_count    <= cnt_nxt;
      out_result_r.last_of_row    <= s1_last_row_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  `CHK_SAME(a_run_has_partner, state_r == ST_RUN, rem_r != '0,
            "sequencer running with no partner left")
  `CHK_NEXT(a_gap_after_row, out_valid && out_result.last_of_row, !out_valid,
            "result beat directly after the last beat of a row")
  `CHK_SAME(a_pop_only_idle, pop, state_r == ST_IDLE,
            "job taken while a row is still running")

endmodule

`default_nettype wire
